// File: rtl/core/smma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smma_pkg: shared types and constants of the scaled matrix multiply core
// Holds command codes, register indexes, datapath widths, multiplier operand
// selects and the control bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package smma_pkg;

    // Field widths.
    localparam int ELEM_W    = 16;
    localparam int IDX_W     = 3;
    localparam int CMD_W     = 2;
    localparam int SIZE_W    = 4;
    localparam int REG_IDX_W = 3;

    // Index reach of the 3-bit row and column fields.
    localparam int INDEX_SPAN = 8;

    // Datapath widths: one 16 x 18 signed multiplier feeds everything.
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = ELEM_W + MUL_B_W;
    localparam int ACC_W   = 35;
    localparam int LO_W    = 17;
    localparam int SCL_W   = ELEM_W + ACC_W;
    localparam int SUM_W   = 36;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_C = 2'd2;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BETA  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INNER = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COLS  = 3'd4;

    // Multiplier operand selects.
    localparam logic [1:0] SEL_AB  = 2'd0;
    localparam logic [1:0] SEL_ALO = 2'd1;
    localparam logic [1:0] SEL_AHI = 2'd2;
    localparam logic [1:0] SEL_BC  = 2'd3;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_clear;
        logic       acc_add;
        logic       scl_load;
        logic       scl_add;
        logic       finish;
    } smma_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/smma_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smma_ram: element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smma_ram #(
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [smma_pkg::ELEM_W-1:0]               wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [smma_pkg::ELEM_W-1:0]               rdata
);

    logic [smma_pkg::ELEM_W-1:0] mem [DEPTH];
    logic [smma_pkg::ELEM_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/smma_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smma_mac: shared multiply-accumulate datapath
// One registered 16 x 18 signed multiplier serves the inner products, the
// two halves of alpha times the sum and beta times the prior C entry.
// ----------------------------------------------------------------------------
module smma_mac (
    input  wire logic                          clk,
    input  wire smma_pkg::smma_ctrl_t          ctrl,
    input  wire logic [smma_pkg::ELEM_W-1:0]   alpha,
    input  wire logic [smma_pkg::ELEM_W-1:0]   beta,
    input  wire logic [smma_pkg::ELEM_W-1:0]   a_data,
    input  wire logic [smma_pkg::ELEM_W-1:0]   b_data,
    input  wire logic [smma_pkg::ELEM_W-1:0]   c_data,
    output logic      [smma_pkg::ELEM_W-1:0]   sat_value,
    output logic      [smma_pkg::ELEM_W-1:0]   out_value
);

    logic signed [smma_pkg::ELEM_W-1:0]  mul_a;
    logic signed [smma_pkg::MUL_B_W-1:0] mul_b;
    logic signed [smma_pkg::PROD_W-1:0]  prod_next;
    logic signed [smma_pkg::PROD_W-1:0]  prod_reg;
    logic signed [smma_pkg::ACC_W-1:0]   acc_reg;
    logic signed [smma_pkg::SCL_W-1:0]   scl_reg;
    logic signed [smma_pkg::SUM_W-1:0]   total;
    logic        [smma_pkg::ELEM_W-1:0]  out_value_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (ctrl.mul_sel)
            smma_pkg::SEL_AB:
            begin
                mul_a = $signed(a_data);
                mul_b = $signed({{2{b_data[smma_pkg::ELEM_W-1]}}, b_data});
            end
            smma_pkg::SEL_ALO:
            begin
                mul_a = $signed(alpha);
                mul_b = $signed({1'b0, acc_reg[smma_pkg::LO_W-1:0]});
            end
            smma_pkg::SEL_AHI:
            begin
                mul_a = $signed(alpha);
                mul_b = $signed(acc_reg[smma_pkg::ACC_W-1:smma_pkg::LO_W]);
            end
            default:
            begin
                mul_a = $signed(beta);
                mul_b = $signed({{2{c_data[smma_pkg::ELEM_W-1]}}, c_data});
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Inner product accumulator.
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + {prod_reg[smma_pkg::PROD_W-1], prod_reg};
        end
    end

    // Scaled sum: low half first, then the high half shifted up.
    always_ff @(posedge clk)
    begin
        if (ctrl.scl_load)
        begin
            scl_reg <= {{(smma_pkg::SCL_W - smma_pkg::PROD_W){prod_reg[smma_pkg::PROD_W-1]}},
                        prod_reg};
        end
        else if (ctrl.scl_add)
        begin
            scl_reg <= scl_reg + {prod_reg, {smma_pkg::LO_W{1'b0}}};
        end
    end

    // Floor shifts of both terms, their sum and saturation to 16 bits.
    always_comb
    begin
        total = {scl_reg[smma_pkg::SCL_W-1], scl_reg[smma_pkg::SCL_W-1:16]}
              + {{10{prod_reg[smma_pkg::PROD_W-1]}}, prod_reg[smma_pkg::PROD_W-1:8]};
        if (total > 36'sd32767)
        begin
            sat_value = 16'h7FFF;
        end
        else if (total < -36'sd32768)
        begin
            sat_value = 16'h8000;
        end
        else
        begin
            sat_value = total[smma_pkg::ELEM_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_value_reg <= sat_value;
        end
    end

    assign out_value = out_value_reg;

endmodule
`default_nettype wire

// File: rtl/core/smma_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smma_seq: run sequencer
// Walks the C entries row-major, streams the inner products through the
// shared multiplier, then steps through scaling, saturation and write-back.
// ----------------------------------------------------------------------------
module smma_seq #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_INNER = 8,
    parameter int MAX_COLS  = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  run,
    input  wire logic [smma_pkg::SIZE_W-1:0]           rows_in_use,
    input  wire logic [smma_pkg::SIZE_W-1:0]           inner_in_use,
    input  wire logic [smma_pkg::SIZE_W-1:0]           cols_in_use,
    output smma_pkg::smma_ctrl_t                       ctrl,
    output logic                                       busy,
    output logic [((MAX_ROWS * MAX_INNER > 1) ? $clog2(MAX_ROWS * MAX_INNER) : 1)-1:0] a_addr,
    output logic [((MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1)-1:0] b_addr,
    output logic [((MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0]   c_addr,
    output logic                                       result_strobe,
    output logic [smma_pkg::IDX_W-1:0]                 out_row,
    output logic [smma_pkg::IDX_W-1:0]                 out_col,
    output logic                                       last
);

    localparam int A_AW = (MAX_ROWS * MAX_INNER > 1) ? $clog2(MAX_ROWS * MAX_INNER) : 1;
    localparam int B_AW = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1;
    localparam int C_AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_BETA  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int IW = smma_pkg::IDX_W;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] p_reg, p_next;
    logic [IW-1:0] m_last_reg, m_last_next;
    logic [IW-1:0] k_last_reg, k_last_next;
    logic [IW-1:0] n_last_reg, n_last_next;
    logic          rd_v_reg, pr_v_reg;
    logic          strobe_reg;
    logic [IW-1:0] row_reg, col_reg;
    logic          last_reg;
    logic          entry_last;

    // Last index in use: zero acts as one, large values stop at the store size.
    function automatic logic [IW-1:0] clamp_last(input logic [smma_pkg::SIZE_W-1:0] size,
                                                 input int limit);
        int top;
        top = (limit < smma_pkg::INDEX_SPAN) ? limit : smma_pkg::INDEX_SPAN;
        if (size == '0)
        begin
            return '0;
        end
        else if (int'(size) > top)
        begin
            return IW'(top - 1);
        end
        else
        begin
            return IW'(int'(size) - 1);
        end
    endfunction

    // Store addresses for the current entry and inner step.
    assign a_addr = A_AW'(int'(i_reg) * MAX_INNER + int'(p_reg));
    assign b_addr = B_AW'(int'(p_reg) * MAX_COLS + int'(j_reg));
    assign c_addr = C_AW'(int'(i_reg) * MAX_COLS + int'(j_reg));

    assign entry_last = (i_reg == m_last_reg) && (j_reg == n_last_reg);

    // Next state, counters and datapath control.
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        m_last_next = m_last_reg;
        k_last_next = k_last_reg;
        n_last_next = n_last_reg;
        ctrl        = '0;

        // Inner products stream: read data now valid feeds the multiplier.
        if (rd_v_reg)
        begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = smma_pkg::SEL_AB;
        end
        ctrl.acc_add = pr_v_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (run)
                begin
                    m_last_next = clamp_last(rows_in_use, MAX_ROWS);
                    k_last_next = clamp_last(inner_in_use, MAX_INNER);
                    n_last_next = clamp_last(cols_in_use, MAX_COLS);
                    i_next      = '0;
                    j_next      = '0;
                    p_next      = '0;
                    state_next  = S_MAC;
                end
            end
            S_MAC:
            begin
                ctrl.acc_clear = (p_reg == '0);
                if (p_reg == k_last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!rd_v_reg && !pr_v_reg)
                begin
                    ctrl.mul_en  = 1'b1;
                    ctrl.mul_sel = smma_pkg::SEL_ALO;
                    state_next   = S_HI;
                end
            end
            S_HI:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = smma_pkg::SEL_AHI;
                ctrl.scl_load = 1'b1;
                state_next    = S_BETA;
            end
            S_BETA:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = smma_pkg::SEL_BC;
                ctrl.scl_add = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                ctrl.finish = 1'b1;
                p_next      = '0;
                if (entry_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MAC;
                    if (j_reg == n_last_reg)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            p_reg      <= '0;
            m_last_reg <= '0;
            k_last_reg <= '0;
            n_last_reg <= '0;
            rd_v_reg   <= 1'b0;
            pr_v_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            p_reg      <= p_next;
            m_last_reg <= m_last_next;
            k_last_reg <= k_last_next;
            n_last_reg <= n_last_next;
            rd_v_reg   <= (state_reg == S_MAC);
            pr_v_reg   <= rd_v_reg;
            strobe_reg <= (state_reg == S_OUT);
        end
    end

    // Result beat tags, captured with the value.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            row_reg  <= i_reg;
            col_reg  <= j_reg;
            last_reg <= entry_last;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign out_row       = row_reg;
    assign out_col       = col_reg;
    assign last          = strobe_reg & last_reg;

endmodule
`default_nettype wire

// File: rtl/core/scaled_matrix_multiply_accumulate_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_accumulate_core: C = alpha*A*B + beta*C
// Loads single Q8.8 elements into the A, B and C stores; a start beat emits
// every C entry in use, row-major, and writes it back into the C store.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-------------------------------
//   command  | start, accepted when !busy | command, row_index, col_index,
//            |                            | element
//   config   | wr_en, no wait             | wr_index, wr_data
//   result   | result_strobe, one cycle   | out_row, out_col, out_value,
//            |                            | last
//
// A load beat leaves busy low.
// During a start beat each entry streams its inner products through the one
// shared multiplier, then steps through pipeline drain, the two halves of
// the alpha product, the beta product and saturation with write-back.
// Reset clears control state and sets the registers to their reset values.
// The result side cannot stall; each result beat is shown for one cycle.
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_accumulate_core #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_INNER = 8,
    parameter int MAX_COLS  = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [smma_pkg::CMD_W-1:0]         command,
    input  wire logic [smma_pkg::IDX_W-1:0]         row_index,
    input  wire logic [smma_pkg::IDX_W-1:0]         col_index,
    input  wire logic [smma_pkg::ELEM_W-1:0]        element,
    input  wire logic                               wr_en,
    input  wire logic [smma_pkg::REG_IDX_W-1:0]     wr_index,
    input  wire logic [smma_pkg::ELEM_W-1:0]        wr_data,
    output logic                                    result_strobe,
    output logic [smma_pkg::IDX_W-1:0]              out_row,
    output logic [smma_pkg::IDX_W-1:0]              out_col,
    output logic [smma_pkg::ELEM_W-1:0]             out_value,
    output logic                                    last
);

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

    logic [smma_pkg::ELEM_W-1:0] alpha_reg;
    logic [smma_pkg::ELEM_W-1:0] beta_reg;
    logic [smma_pkg::SIZE_W-1:0] rows_reg;
    logic [smma_pkg::SIZE_W-1:0] inner_reg;
    logic [smma_pkg::SIZE_W-1:0] cols_reg;

    logic                        accept;
    logic                        run;
    logic                        a_we, b_we, c_load;
    logic                        c_we;
    logic [A_AW-1:0]             a_waddr, a_raddr;
    logic [B_AW-1:0]             b_waddr, b_raddr;
    logic [C_AW-1:0]             c_laddr, c_addr, c_waddr;
    logic [smma_pkg::ELEM_W-1:0] c_wdata;
    logic [smma_pkg::ELEM_W-1:0] a_data, b_data, c_data;
    logic [smma_pkg::ELEM_W-1:0] sat_value;
    smma_pkg::smma_ctrl_t        ctrl;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'd256;
            beta_reg  <= '0;
            rows_reg  <= 4'd8;
            inner_reg <= 4'd8;
            cols_reg  <= 4'd8;
        end
        else if (wr_en)
        begin
            case (wr_index)
                smma_pkg::REG_ALPHA: alpha_reg <= wr_data;
                smma_pkg::REG_BETA:  beta_reg  <= wr_data;
                smma_pkg::REG_ROWS:  rows_reg  <= wr_data[smma_pkg::SIZE_W-1:0];
                smma_pkg::REG_INNER: inner_reg <= wr_data[smma_pkg::SIZE_W-1:0];
                smma_pkg::REG_COLS:  cols_reg  <= wr_data[smma_pkg::SIZE_W-1:0];
                default:             ;
            endcase
        end
    end

    // Command decode; loads outside a store's size are dropped.
    assign accept = start && !busy;
    assign run    = accept && (command == smma_pkg::CMD_START);
    assign a_we   = accept && (command == smma_pkg::CMD_LOAD_A)
                  && (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_INNER);
    assign b_we   = accept && (command == smma_pkg::CMD_LOAD_B)
                  && (int'(row_index) < MAX_INNER) && (int'(col_index) < MAX_COLS);
    assign c_load = accept && (command == smma_pkg::CMD_LOAD_C)
                  && (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);

    assign a_waddr = A_AW'(int'(row_index) * MAX_INNER + int'(col_index));
    assign b_waddr = B_AW'(int'(row_index) * MAX_COLS + int'(col_index));
    assign c_laddr = C_AW'(int'(row_index) * MAX_COLS + int'(col_index));

    // The C store takes loads when idle and write-backs during a run.
    assign c_we    = c_load || ctrl.finish;
    assign c_waddr = ctrl.finish ? c_addr : c_laddr;
    assign c_wdata = ctrl.finish ? sat_value : element;

    smma_ram #(.DEPTH(A_DEPTH)) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (element),
        .raddr (a_raddr),
        .rdata (a_data)
    );

    smma_ram #(.DEPTH(B_DEPTH)) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (element),
        .raddr (b_raddr),
        .rdata (b_data)
    );

    smma_ram #(.DEPTH(C_DEPTH)) u_c_store (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_addr),
        .rdata (c_data)
    );

    smma_seq #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .run           (run),
        .rows_in_use   (rows_reg),
        .inner_in_use  (inner_reg),
        .cols_in_use   (cols_reg),
        .ctrl          (ctrl),
        .busy          (busy),
        .a_addr        (a_raddr),
        .b_addr        (b_raddr),
        .c_addr        (c_addr),
        .result_strobe (result_strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .last          (last)
    );

    smma_mac u_mac (
        .clk       (clk),
        .ctrl      (ctrl),
        .alpha     (alpha_reg),
        .beta      (beta_reg),
        .a_data    (a_data),
        .b_data    (b_data),
        .c_data    (c_data),
        .sat_value (sat_value),
        .out_value (out_value)
    );

endmodule
`default_nettype wire

// File: rtl/core/smma_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smma_checker: port-level checks for the matrix multiply core
// Watches the command and result ports and ties result beats to the run.
// ----------------------------------------------------------------------------
module smma_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [smma_pkg::CMD_W-1:0]   command,
    input  wire logic                         result_strobe,
    input  wire logic                         last
);

    // A start beat opens a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == smma_pkg::CMD_START)) |=> busy)
    else $error("start beat did not raise busy");

    // A load beat finishes in its own cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != smma_pkg::CMD_START)) |=> !busy)
    else $error("load beat left the core busy");

    // Every result beat belongs to a run that was under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
    else $error("result beat outside a run");

    // The last beat ends the run; earlier beats keep it going.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (last != busy))
    else $error("busy does not match the last mark");

    // The last mark only travels with a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_strobe)
    else $error("last mark without a result beat");

endmodule

bind scaled_matrix_multiply_accumulate_core smma_checker u_smma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .result_strobe (result_strobe),
    .last          (last)
);
`default_nettype wire

// File: tb/scaled_matrix_multiply_accumulate_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_accumulate_core_tb: self-checking bench for the core
// Loads the A, B and C stores and issues start beats under many register
// settings. An in-bench predictor computes every C entry of each start beat,
// and a monitor compares each result beat with the oldest predicted entry.
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_accumulate_core_tb;

    localparam int MAX_ROWS   = 8;
    localparam int MAX_INNER  = 8;
    localparam int MAX_COLS   = 8;
    localparam int RANDOM_BEATS = 370;
    localparam int JUNK_W     = smma_pkg::ELEM_W - smma_pkg::SIZE_W;

    // One command beat as it goes to the block.
    typedef struct {
        logic [smma_pkg::CMD_W-1:0]  cmd;
        logic [smma_pkg::IDX_W-1:0]  row;
        logic [smma_pkg::IDX_W-1:0]  col;
        logic [smma_pkg::ELEM_W-1:0] elem;
    } command_beat_t;

    // One C entry as the block reports it.
    typedef struct {
        logic [smma_pkg::IDX_W-1:0]  row;
        logic [smma_pkg::IDX_W-1:0]  col;
        logic [smma_pkg::ELEM_W-1:0] value;
        logic                        last;
    } c_entry_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           start     = 1'b0;
    logic [smma_pkg::CMD_W-1:0]     command   = smma_pkg::CMD_LOAD_A;
    logic [smma_pkg::IDX_W-1:0]     row_index = '0;
    logic [smma_pkg::IDX_W-1:0]     col_index = '0;
    logic [smma_pkg::ELEM_W-1:0]    element   = '0;
    logic                           wr_en     = 1'b0;
    logic [smma_pkg::REG_IDX_W-1:0] wr_index  = smma_pkg::REG_ALPHA;
    logic [smma_pkg::ELEM_W-1:0]    wr_data   = '0;
    logic                           busy;
    logic                           result_strobe;
    logic [smma_pkg::IDX_W-1:0]     out_row;
    logic [smma_pkg::IDX_W-1:0]     out_col;
    logic [smma_pkg::ELEM_W-1:0]    out_value;
    logic                           last;

    // Predictor state: register copies and the three stores.
    logic signed [smma_pkg::ELEM_W-1:0] alpha_q = 16'sh0100;
    logic signed [smma_pkg::ELEM_W-1:0] beta_q  = 16'sh0000;
    logic [smma_pkg::SIZE_W-1:0]        rows_q  = 4'd8;
    logic [smma_pkg::SIZE_W-1:0]        inner_q = 4'd8;
    logic [smma_pkg::SIZE_W-1:0]        cols_q  = 4'd8;
    logic signed [smma_pkg::ELEM_W-1:0] a_mem [MAX_ROWS][MAX_INNER];
    logic signed [smma_pkg::ELEM_W-1:0] b_mem [MAX_INNER][MAX_COLS];
    logic signed [smma_pkg::ELEM_W-1:0] c_mem [MAX_ROWS][MAX_COLS];

    // Stimulus bookkeeping: which store entries hold a written value.
    bit a_loaded [MAX_ROWS][MAX_INNER];
    bit b_loaded [MAX_INNER][MAX_COLS];
    bit c_loaded [MAX_ROWS][MAX_COLS];

    command_beat_t command_beats[$];
    c_entry_t      c_entries_due[$];
    command_beat_t held_beat;
    int            beats_queued = 0;
    int            mismatches   = 0;
    int            gap_left     = 0;
    int            burst_left   = 0;

    scaled_matrix_multiply_accumulate_core #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .row_index     (row_index),
        .col_index     (col_index),
        .element       (element),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .result_strobe (result_strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last          (last)
    );

    always #10 clk = ~clk;

    // Effective size of a size register: zero acts as one, large values clip.
    function automatic int span_of(input logic [smma_pkg::SIZE_W-1:0] reg_val,
                                   input int limit);
        int top;
        top = (limit < smma_pkg::INDEX_SPAN) ? limit : smma_pkg::INDEX_SPAN;
        if (reg_val == 0)
            return 1;
        return (reg_val > top) ? top : int'(reg_val);
    endfunction

    // Applies one accepted beat to the stores and queues the C entries it yields.
    function automatic void apply_command(input command_beat_t cb);
        int       m;
        int       k;
        int       n;
        int       i;
        int       j;
        int       p;
        longint   acc;
        longint   scaled;
        c_entry_t ent;
        case (cb.cmd)
            smma_pkg::CMD_LOAD_A:
                if (cb.row < MAX_ROWS && cb.col < MAX_INNER)
                    a_mem[cb.row][cb.col] = cb.elem;
            smma_pkg::CMD_LOAD_B:
                if (cb.row < MAX_INNER && cb.col < MAX_COLS)
                    b_mem[cb.row][cb.col] = cb.elem;
            smma_pkg::CMD_LOAD_C:
                if (cb.row < MAX_ROWS && cb.col < MAX_COLS)
                    c_mem[cb.row][cb.col] = cb.elem;
            default:
            begin
                m = span_of(rows_q, MAX_ROWS);
                k = span_of(inner_q, MAX_INNER);
                n = span_of(cols_q, MAX_COLS);
                for (i = 0; i < m; i++)
                begin
                    for (j = 0; j < n; j++)
                    begin
                        acc = 0;
                        for (p = 0; p < k; p++)
                            acc += longint'(a_mem[i][p]) * longint'(b_mem[p][j]);
                        // Both scaled terms use floor shifts before they are summed.
                        scaled = ((longint'(alpha_q) * acc) >>> 16) +
                                 ((longint'(beta_q) * longint'(c_mem[i][j])) >>> 8);
                        if (scaled > 32767)
                            scaled = 32767;
                        if (scaled < -32768)
                            scaled = -32768;
                        c_mem[i][j] = scaled[15:0];
                        ent.row   = 3'(i);
                        ent.col   = 3'(j);
                        ent.value = scaled[15:0];
                        ent.last  = (i == m - 1) && (j == n - 1);
                        c_entries_due.push_back(ent);
                    end
                end
            end
        endcase
    endfunction

    // Element values: extremes, full-range noise and small Q8.8 numbers.
    function automatic logic [smma_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    function automatic logic [smma_pkg::ELEM_W-1:0] rand_scale();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0100;
            4: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    // Mostly small sizes; now and then zero or a large value of 8 to 15.
    function automatic logic [smma_pkg::SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 7))
            0: return 4'd0;
            1: return 4'($urandom_range(8, 15));
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // Queues one beat and tracks which store entries now hold data.
    task automatic push_beat(input logic [smma_pkg::CMD_W-1:0] op,
                             input logic [smma_pkg::IDX_W-1:0] r,
                             input logic [smma_pkg::IDX_W-1:0] c,
                             input logic [smma_pkg::ELEM_W-1:0] e);
        command_beat_t cb;
        int            i;
        int            j;
        cb.cmd  = op;
        cb.row  = r;
        cb.col  = c;
        cb.elem = e;
        command_beats.push_back(cb);
        beats_queued++;
        case (op)
            smma_pkg::CMD_LOAD_A: a_loaded[r][c] = 1'b1;
            smma_pkg::CMD_LOAD_B: b_loaded[r][c] = 1'b1;
            smma_pkg::CMD_LOAD_C: c_loaded[r][c] = 1'b1;
            default:
            begin
                for (i = 0; i < span_of(rows_q, MAX_ROWS); i++)
                    for (j = 0; j < span_of(cols_q, MAX_COLS); j++)
                        c_loaded[i][j] = 1'b1;
            end
        endcase
    endtask

    // Fills any store entry the start would read but was never written, then starts.
    task automatic push_start();
        int m;
        int k;
        int n;
        int i;
        int j;
        m = span_of(rows_q, MAX_ROWS);
        k = span_of(inner_q, MAX_INNER);
        n = span_of(cols_q, MAX_COLS);
        for (i = 0; i < m; i++)
            for (j = 0; j < k; j++)
                if (!a_loaded[i][j])
                    push_beat(smma_pkg::CMD_LOAD_A, 3'(i), 3'(j), rand_elem());
        for (i = 0; i < k; i++)
            for (j = 0; j < n; j++)
                if (!b_loaded[i][j])
                    push_beat(smma_pkg::CMD_LOAD_B, 3'(i), 3'(j), rand_elem());
        for (i = 0; i < m; i++)
            for (j = 0; j < n; j++)
                if (!c_loaded[i][j])
                    push_beat(smma_pkg::CMD_LOAD_C, 3'(i), 3'(j), rand_elem());
        push_beat(smma_pkg::CMD_START, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    // Waits until every beat is taken, every entry has arrived and the core is quiet.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (command_beats.size() != 0 || start || c_entries_due.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [smma_pkg::REG_IDX_W-1:0] idx,
                             input logic [smma_pkg::ELEM_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            smma_pkg::REG_ALPHA: alpha_q = data;
            smma_pkg::REG_BETA:  beta_q  = data;
            smma_pkg::REG_ROWS:  rows_q  = data[smma_pkg::SIZE_W-1:0];
            smma_pkg::REG_INNER: inner_q = data[smma_pkg::SIZE_W-1:0];
            smma_pkg::REG_COLS:  cols_q  = data[smma_pkg::SIZE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Reprograms all registers once the core is idle; size writes carry junk upper bits.
    task automatic configure(input logic [smma_pkg::ELEM_W-1:0] al,
                             input logic [smma_pkg::ELEM_W-1:0] be,
                             input logic [smma_pkg::SIZE_W-1:0] m,
                             input logic [smma_pkg::SIZE_W-1:0] k,
                             input logic [smma_pkg::SIZE_W-1:0] n);
        logic [JUNK_W-1:0] junk;
        wait_idle();
        write_reg(smma_pkg::REG_ALPHA, al);
        write_reg(smma_pkg::REG_BETA, be);
        junk = JUNK_W'($urandom);
        write_reg(smma_pkg::REG_ROWS, {junk, m});
        junk = JUNK_W'($urandom);
        write_reg(smma_pkg::REG_INNER, {junk, k});
        junk = JUNK_W'($urandom);
        write_reg(smma_pkg::REG_COLS, {junk, n});
        // Indexes past the last register must be ignored.
        if ($urandom_range(0, 2) == 0)
            write_reg(smma_pkg::REG_IDX_W'(smma_pkg::REG_COLS + 1 + $urandom_range(0, 2)),
                      16'($urandom));
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                apply_command(held_beat);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (command_beats.size() != 0)
                begin
                    held_beat = command_beats.pop_front();
                    start     <= 1'b1;
                    command   <= held_beat.cmd;
                    row_index <= held_beat.row;
                    col_index <= held_beat.col;
                    element   <= held_beat.elem;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: each strobed beat must match the oldest predicted C entry.
    always @(posedge clk)
    begin : result_monitor
        c_entry_t want;
        if (rst_n && result_strobe)
        begin
            if (c_entries_due.size() == 0)
            begin
                $error("result beat with nothing expected: row %0d col %0d value %0d",
                       out_row, out_col, $signed(out_value));
                mismatches++;
            end
            else
            begin
                want = c_entries_due.pop_front();
                if (out_row !== want.row)
                begin
                    $error("out_row: expected %0d, got %0d", want.row, out_row);
                    mismatches++;
                end
                if (out_col !== want.col)
                begin
                    $error("out_col: expected %0d, got %0d", want.col, out_col);
                    mismatches++;
                end
                if (out_value !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d",
                           $signed(want.value), $signed(out_value));
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: directed corner cases, then random phases under varied settings.
    initial
    begin : stimulus
        int                         random_target;
        int                         phase_len;
        int                         pick;
        int                         lim_r;
        int                         lim_c;
        int                         guard;
        logic [smma_pkg::CMD_W-1:0] op;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Size registers of zero act as one; positive saturation; a tiny negative product.
        configure(16'h0100, 16'h0000, 4'd0, 4'd0, 4'd0);
        push_beat(smma_pkg::CMD_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
        push_beat(smma_pkg::CMD_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
        push_beat(smma_pkg::CMD_LOAD_C, 3'd0, 3'd0, 16'h8000);
        push_start();
        push_beat(smma_pkg::CMD_LOAD_A, 3'd0, 3'd0, 16'hFFFF);
        push_beat(smma_pkg::CMD_LOAD_B, 3'd0, 3'd0, 16'h0100);
        push_start();

        // Most negative scales drive the entry into negative saturation.
        configure(16'h8000, 16'h8000, 4'd1, 4'd2, 4'd1);
        push_beat(smma_pkg::CMD_LOAD_A, 3'd0, 3'd1, 16'h8000);
        push_beat(smma_pkg::CMD_LOAD_B, 3'd1, 3'd0, 16'h8000);
        push_start();

        // Loads at the far corner, then a small 2x1x2 product with largest scales.
        configure(16'h7FFF, 16'h7FFF, 4'd2, 4'd1, 4'd2);
        push_beat(smma_pkg::CMD_LOAD_A, 3'd7, 3'd7, 16'h7FFF);
        push_beat(smma_pkg::CMD_LOAD_B, 3'd7, 3'd7, 16'h8000);
        push_beat(smma_pkg::CMD_LOAD_C, 3'd7, 3'd7, 16'h0000);
        push_start();

        // Alpha of minus one LSB checks the floor shift on the product term.
        configure(16'hFFFF, 16'h0001, 4'd1, 4'd1, 4'd1);
        push_start();

        // Oversized size registers clip to the full 8x8x8 problem.
        random_target = beats_queued + RANDOM_BEATS;
        configure(16'h7FFF, 16'h8000, 4'd15, 4'd8, 4'd15);
        push_start();
        push_start();

        while (beats_queued < random_target)
        begin
            configure(rand_scale(), rand_scale(), rand_size(), rand_size(), rand_size());
            phase_len = $urandom_range(25, 45);
            while (phase_len > 0 && beats_queued < random_target)
            begin
                phase_len--;
                pick = $urandom_range(0, 9);
                if (pick >= 7)
                begin
                    push_start();
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: op = smma_pkg::CMD_LOAD_A;
                        1: op = smma_pkg::CMD_LOAD_B;
                        default: op = smma_pkg::CMD_LOAD_C;
                    endcase
                    if (pick == 6)
                    begin
                        push_beat(op, 3'($urandom), 3'($urandom), rand_elem());
                    end
                    else
                    begin
                        // Reload an entry the next start will actually read.
                        lim_r = (op == smma_pkg::CMD_LOAD_B) ? span_of(inner_q, MAX_INNER)
                                                             : span_of(rows_q, MAX_ROWS);
                        lim_c = (op == smma_pkg::CMD_LOAD_A) ? span_of(inner_q, MAX_INNER)
                                                             : span_of(cols_q, MAX_COLS);
                        push_beat(op, 3'($urandom_range(0, lim_r - 1)),
                                  3'($urandom_range(0, lim_c - 1)), rand_elem());
                    end
                end
            end
        end

        // Drain: all beats taken, all entries back, then a short quiet period.
        do
            @(negedge clk);
        while (command_beats.size() != 0 || start);
        guard = 0;
        while (c_entries_due.size() != 0 && guard < 4000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);
        if (c_entries_due.size() != 0)
            $error("%0d expected C entries never arrived", c_entries_due.size());
        if (mismatches == 0 && c_entries_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
